[rtl/point_in_ellipsoid_test_top_macros.svh]
// assertion helpers for the point-in-ellipsoid block
// every helper samples on clock and is switched off while reset is high
`ifndef POINT_IN_ELLIPSOID_TEST_TOP_MACROS_SVH
`define POINT_IN_ELLIPSOID_TEST_TOP_MACROS_SVH

// same-cycle implication
`define PIE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication in the next cycle
`define PIE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// implication after a fixed number of cycles
`define PIE_ASSERT_LAT(label, ante, n, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(n) (cons)) \
      else $error(msg);

`endif

[rtl/pie_pkg.sv]
`default_nettype none
package pie_pkg;

   localparam int COORD_WIDTH_DEF = 21;

   // register file
   localparam int CSR_WIDTH   = 63;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_IDX_LSB = 3;
   localparam int CSR_IDX_W   = CSR_ADDR_W - CSR_IDX_LSB;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_ONE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_TWO   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_THREE = 2'd3;

   // register stages from accept to the result strobe
   localparam int PIPE_DEPTH = 9;

endpackage
`default_nettype wire

[rtl/pie_core.sv]
`default_nettype none
module pie_core #(
   parameter int COORD_WIDTH = pie_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [COORD_WIDTH-1:0] point_x,
   input  wire logic signed [COORD_WIDTH-1:0] point_y,
   input  wire logic signed [COORD_WIDTH-1:0] point_z,
   input  wire logic [3*COORD_WIDTH-1:0]      center,
   input  wire logic [3*COORD_WIDTH-1:0]      axis_one,
   input  wire logic [3*COORD_WIDTH-1:0]      axis_two,
   input  wire logic [3*COORD_WIDTH-1:0]      axis_three,
   output logic                               out_valid,
   output logic                               hit
);

   localparam int W  = COORD_WIDTH;
   localparam int OW = W + 1;          // offset
   localparam int CW = 2 * W + 2;      // cross product component
   localparam int TW = 3 * W + 3;      // determinant term
   localparam int DW = 3 * W + 5;      // determinant
   localparam int HW = (DW + 1) / 2;   // low half of a magnitude
   localparam int GW = DW - HW;        // high half of a magnitude
   localparam int SW = 2 * DW;         // square
   localparam int AW = SW + 2;         // sum of three squares
   localparam int NS = pie_pkg::PIPE_DEPTH;

   logic signed [W-1:0] pt  [3];
   logic signed [W-1:0] ctr [3];
   logic signed [W-1:0] ax1 [3];
   logic signed [W-1:0] ax2 [3];
   logic signed [W-1:0] ax3 [3];

   assign pt[0] = point_x;
   assign pt[1] = point_y;
   assign pt[2] = point_z;

   genvar k;
   generate
      for (k = 0; k < 3; k++) begin : g_unpack
         assign ctr[k] = center[k*W +: W];
         assign ax1[k] = axis_one[k*W +: W];
         assign ax2[k] = axis_two[k*W +: W];
         assign ax3[k] = axis_three[k*W +: W];
      end
   endgenerate

   logic [NS-1:0] vld_ff;

   // stage 1: offset from the center
   logic signed [OW-1:0] off_in [3];
   logic signed [OW-1:0] off_ff [3];

   // stage 2: cross products v1 x v2, off x v2, v1 x off
   logic signed [CW-1:0] x12_in [3];
   logic signed [CW-1:0] xo2_in [3];
   logic signed [CW-1:0] x1o_in [3];
   logic signed [CW-1:0] x12_ff [3];
   logic signed [CW-1:0] xo2_ff [3];
   logic signed [CW-1:0] x1o_ff [3];
   logic signed [OW-1:0] off2_ff [3];

   // stage 3: dot product terms, row j is determinant j
   logic signed [TW-1:0] t_in [4][3];
   logic signed [TW-1:0] t_ff [4][3];

   // stage 4 and 5: determinants and their magnitudes
   logic signed [DW-1:0] d_in  [4];
   logic signed [DW-1:0] d_ff  [4];
   logic [DW-1:0]        mag_in [4];
   logic [DW-1:0]        mag_ff [4];

   // stage 6 and 7: split squaring
   logic [2*HW-1:0]      ll_in [4];
   logic [GW+HW-1:0]     lh_in [4];
   logic [2*GW-1:0]      hh_in [4];
   logic [2*HW-1:0]      ll_ff [4];
   logic [GW+HW-1:0]     lh_ff [4];
   logic [2*GW-1:0]      hh_ff [4];
   logic [SW-1:0]        sq_in [4];
   logic [SW-1:0]        sq_ff [4];

   // stage 8 and 9: sum and compare
   logic [AW-1:0]        sum_in;
   logic [AW-1:0]        sum_ff;
   logic [SW-1:0]        d4sq_ff;
   logic                 inside_in;
   logic                 inside_ff;

   generate
      for (k = 0; k < 3; k++) begin : g_cross
         localparam int I1 = (k + 1) % 3;
         localparam int I2 = (k + 2) % 3;
         logic signed [2*W-1:0]  pa12;
         logic signed [2*W-1:0]  pb12;
         logic signed [OW+W-1:0] pao2;
         logic signed [OW+W-1:0] pbo2;
         logic signed [OW+W-1:0] pa1o;
         logic signed [OW+W-1:0] pb1o;
         logic signed [TW-1:0]   p1;
         logic signed [W+CW-1:0] p2;
         logic signed [W+CW-1:0] p3;
         logic signed [W+CW-1:0] p4;

         assign off_in[k] = OW'(pt[k]) - OW'(ctr[k]);

         assign pa12 = ax2[I1] * ax3[I2];
         assign pb12 = ax2[I2] * ax3[I1];
         assign pao2 = off_ff[I1] * ax3[I2];
         assign pbo2 = off_ff[I2] * ax3[I1];
         assign pa1o = ax2[I1] * off_ff[I2];
         assign pb1o = ax2[I2] * off_ff[I1];
         assign x12_in[k] = CW'(pa12) - CW'(pb12);
         assign xo2_in[k] = CW'(pao2) - CW'(pbo2);
         assign x1o_in[k] = CW'(pa1o) - CW'(pb1o);

         // cramer rows: off.(v1xv2), v0.(offxv2), v0.(v1xoff), v0.(v1xv2)
         assign p1 = off2_ff[k] * x12_ff[k];
         assign p2 = ax1[k] * xo2_ff[k];
         assign p3 = ax1[k] * x1o_ff[k];
         assign p4 = ax1[k] * x12_ff[k];
         assign t_in[0][k] = p1;
         assign t_in[1][k] = TW'(p2);
         assign t_in[2][k] = TW'(p3);
         assign t_in[3][k] = TW'(p4);
      end

      for (k = 0; k < 4; k++) begin : g_square
         logic [HW-1:0] lo;
         logic [GW-1:0] hi;

         assign d_in[k] = DW'(t_ff[k][0]) + DW'(t_ff[k][1]) + DW'(t_ff[k][2]);
         // most negative value wraps onto itself, which is the right magnitude
         assign mag_in[k] = d_ff[k][DW-1] ? $unsigned(-d_ff[k]) : $unsigned(d_ff[k]);

         assign lo = mag_ff[k][HW-1:0];
         assign hi = mag_ff[k][DW-1:HW];
         assign ll_in[k] = lo * lo;
         assign lh_in[k] = hi * lo;
         assign hh_in[k] = hi * hi;

         assign sq_in[k] = (SW'(hh_ff[k]) << (2 * HW))
                         + (SW'(lh_ff[k]) << (HW + 1))
                         + SW'(ll_ff[k]);
      end
   endgenerate

   assign sum_in    = AW'(sq_ff[0]) + AW'(sq_ff[1]) + AW'(sq_ff[2]);
   assign inside_in = (sum_ff <= AW'(d4sq_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         off_ff[i]  <= off_in[i];
         x12_ff[i]  <= x12_in[i];
         xo2_ff[i]  <= xo2_in[i];
         x1o_ff[i]  <= x1o_in[i];
         off2_ff[i] <= off_ff[i];
      end
      for (int j = 0; j < 4; j++) begin
         for (int i = 0; i < 3; i++) begin
            t_ff[j][i] <= t_in[j][i];
         end
         d_ff[j]   <= d_in[j];
         mag_ff[j] <= mag_in[j];
         ll_ff[j]  <= ll_in[j];
         lh_ff[j]  <= lh_in[j];
         hh_ff[j]  <= hh_in[j];
         sq_ff[j]  <= sq_in[j];
      end
      sum_ff    <= sum_in;
      d4sq_ff   <= sq_ff[3];
      inside_ff <= inside_in;
   end

   assign out_valid = vld_ff[NS-1];
   assign hit       = inside_ff;

endmodule
`default_nettype wire

[rtl/point_in_ellipsoid_test_top.sv]
`default_nettype none
// point-in-ellipsoid test
// the ellipsoid is set through the register port: center, then three axis
// vectors, each as three signed coordinate fields packed x-low, one 64-bit
// register every 8 bytes. write them only while no item is in flight.
// an item (one query point) is taken at a clock edge where start is high and
// busy is low; busy is low at all times except during reset and the cycle
// after it, so a new point can enter on every cycle.
// the block works in 9 register stages: offset, cross products, dot terms,
// determinant sums, magnitudes, split squaring, square assembly, sum, compare.
// rsp_strobe is high for one cycle, as the item leaves the compare stage, with
// rsp_inside_res valid in it; one result per item, in order.
// sustained rate is one item per cycle, set by the fully pipelined datapath.
// the receiver has no stall; results must be taken as they appear.
// reset clears the ellipsoid registers to zero and drops every item in flight.
module point_in_ellipsoid_test_top #(
   parameter int COORD_WIDTH = pie_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [COORD_WIDTH-1:0]       req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0]       req_point_y,
   input  wire logic signed [COORD_WIDTH-1:0]       req_point_z,
   output logic                                     rsp_strobe,
   output logic                                     rsp_inside_res,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [pie_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [pie_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [pie_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                     pready
);

   localparam int RW = pie_pkg::CSR_WIDTH;

   logic                          busy_ff;
   logic [RW-1:0]                 center_ff;
   logic [RW-1:0]                 axis_one_ff;
   logic [RW-1:0]                 axis_two_ff;
   logic [RW-1:0]                 axis_three_ff;
   logic [pie_pkg::CSR_IDX_W-1:0] csr_idx;
   logic                          csr_wr;
   logic                          item_go;

   assign csr_idx = paddr[pie_pkg::CSR_ADDR_W-1:pie_pkg::CSR_IDX_LSB];
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign item_go = start && !busy_ff;
   assign busy    = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff     <= '0;
         axis_one_ff   <= '0;
         axis_two_ff   <= '0;
         axis_three_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            pie_pkg::CSR_CENTER:     center_ff     <= pwdata[RW-1:0];
            pie_pkg::CSR_AXIS_ONE:   axis_one_ff   <= pwdata[RW-1:0];
            pie_pkg::CSR_AXIS_TWO:   axis_two_ff   <= pwdata[RW-1:0];
            pie_pkg::CSR_AXIS_THREE: axis_three_ff <= pwdata[RW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         pie_pkg::CSR_CENTER:     prdata = pie_pkg::CSR_DATA_W'(center_ff);
         pie_pkg::CSR_AXIS_ONE:   prdata = pie_pkg::CSR_DATA_W'(axis_one_ff);
         pie_pkg::CSR_AXIS_TWO:   prdata = pie_pkg::CSR_DATA_W'(axis_two_ff);
         pie_pkg::CSR_AXIS_THREE: prdata = pie_pkg::CSR_DATA_W'(axis_three_ff);
         default:                 prdata = '0;
      endcase
   end

   pie_core #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (item_go),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .point_z    (req_point_z),
      .center     (center_ff[3*COORD_WIDTH-1:0]),
      .axis_one   (axis_one_ff[3*COORD_WIDTH-1:0]),
      .axis_two   (axis_two_ff[3*COORD_WIDTH-1:0]),
      .axis_three (axis_three_ff[3*COORD_WIDTH-1:0]),
      .out_valid  (rsp_strobe),
      .hit        (rsp_inside_res)
   );

`include "point_in_ellipsoid_test_top_macros.svh"

   `PIE_ASSERT_LAT(a_item_gives_result, item_go, pie_pkg::PIPE_DEPTH, rsp_strobe, "item lost in pipeline")
   `PIE_ASSERT_SAME(a_result_has_item, rsp_strobe, $past(item_go, pie_pkg::PIPE_DEPTH), "result without item")
   `PIE_ASSERT_NEXT(a_center_write, csr_wr && (csr_idx == pie_pkg::CSR_CENTER), center_ff == $past(pwdata[RW-1:0]), "center write lost")

endmodule
`default_nettype wire

[bench/point_in_ellipsoid_test_top_test.sv]
`default_nettype none
module point_in_ellipsoid_test_top_test;
   import pie_pkg::*;

   localparam int CW   = COORD_WIDTH_DEF;
   localparam int MAXC = (1 << (CW - 1)) - 1;
   localparam int MINC = -(1 << (CW - 1));

   typedef logic signed [255:0] wide_type;
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 hit;
   } query_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic signed [CW-1:0]  req_point_x = '0;
   logic signed [CW-1:0]  req_point_y = '0;
   logic signed [CW-1:0]  req_point_z = '0;
   logic                  rsp_strobe;
   logic                  rsp_inside_res;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic [CSR_WIDTH-1:0]  csr_shadow [4];
   query_type             pending_inside [$];
   int                    error_count = 0;
   int                    idle_pct = 11;

   always #5 clock = ~clock;

   point_in_ellipsoid_test_top #(
      .COORD_WIDTH(CW)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .rsp_strobe    (rsp_strobe),
      .rsp_inside_res(rsp_inside_res),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // signed coordinate k of a packed register, x in the low bits
   function automatic int coord_at(logic [CSR_WIDTH-1:0] v, int k);
      logic signed [CW-1:0] f;
      f = v[k*CW +: CW];
      return int'(f);
   endfunction

   // a . (b x c)
   function automatic wide_type det3(wide_type ax, wide_type ay, wide_type az,
                                     wide_type bx, wide_type by, wide_type bz,
                                     wide_type cx, wide_type cy, wide_type cz);
      return ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz)
           + az * (bx * cy - by * cx);
   endfunction

   function automatic logic point_inside(logic signed [CW-1:0] px,
                                         logic signed [CW-1:0] py,
                                         logic signed [CW-1:0] pz);
      wide_type ox, oy, oz, ux, uy, uz, vx, vy, vz, wx, wy, wz;
      wide_type d_axes, d_one, d_two, d_three;
      ox = wide_type'(px);
      oy = wide_type'(py);
      oz = wide_type'(pz);
      ox = ox - wide_type'(coord_at(csr_shadow[CSR_CENTER], 0));
      oy = oy - wide_type'(coord_at(csr_shadow[CSR_CENTER], 1));
      oz = oz - wide_type'(coord_at(csr_shadow[CSR_CENTER], 2));
      ux = wide_type'(coord_at(csr_shadow[CSR_AXIS_ONE], 0));
      uy = wide_type'(coord_at(csr_shadow[CSR_AXIS_ONE], 1));
      uz = wide_type'(coord_at(csr_shadow[CSR_AXIS_ONE], 2));
      vx = wide_type'(coord_at(csr_shadow[CSR_AXIS_TWO], 0));
      vy = wide_type'(coord_at(csr_shadow[CSR_AXIS_TWO], 1));
      vz = wide_type'(coord_at(csr_shadow[CSR_AXIS_TWO], 2));
      wx = wide_type'(coord_at(csr_shadow[CSR_AXIS_THREE], 0));
      wy = wide_type'(coord_at(csr_shadow[CSR_AXIS_THREE], 1));
      wz = wide_type'(coord_at(csr_shadow[CSR_AXIS_THREE], 2));
      d_axes  = det3(ux, uy, uz, vx, vy, vz, wx, wy, wz);
      d_one   = det3(ox, oy, oz, vx, vy, vz, wx, wy, wz);
      d_two   = det3(ux, uy, uz, ox, oy, oz, wx, wy, wz);
      d_three = det3(ux, uy, uz, vx, vy, vz, ox, oy, oz);
      return (d_one * d_one + d_two * d_two + d_three * d_three) <= d_axes * d_axes;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pack_coords(int x, int y, int z);
      logic [CW-1:0] fx, fy, fz;
      fx = CW'(x);
      fy = CW'(y);
      fz = CW'(z);
      return {1'b0, fz, fy, fx};
   endfunction

   // spare top bit is ignored by the block, so toggle it at random
   function automatic logic [CSR_DATA_W-1:0] with_spare(logic [CSR_DATA_W-1:0] v);
      v[CSR_DATA_W-1] = 1'($urandom_range(0, 1));
      return v;
   endfunction

   function automatic int rand_coord(int bits);
      int lim;
      lim = 1 << bits;
      return int'($urandom_range(0, 2 * lim - 1)) - lim;
   endfunction

   task automatic send_point(int x, int y, int z);
      query_type q;
      if ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         req_point_x = CW'($urandom);
         req_point_y = CW'($urandom);
         req_point_z = CW'($urandom);
      end
      @(negedge clock);
      start = 1'b1;
      req_point_x = CW'(x);
      req_point_y = CW'(y);
      req_point_z = CW'(z);
      do @(posedge clock); while (busy !== 1'b0);
      q.x = CW'(x);
      q.y = CW'(y);
      q.z = CW'(z);
      q.hit = point_inside(q.x, q.y, q.z);
      pending_inside.push_back(q);
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      start = 1'b0;
      while (pending_inside.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = CSR_ADDR_W'(idx) << CSR_IDX_LSB;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      csr_shadow[idx] = value[CSR_WIDTH-1:0];
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_ellipsoid(logic [CSR_DATA_W-1:0] center, logic [CSR_DATA_W-1:0] a1,
                                logic [CSR_DATA_W-1:0] a2, logic [CSR_DATA_W-1:0] a3);
      wait_all_results();
      write_csr(CSR_CENTER, center);
      write_csr(CSR_AXIS_ONE, a1);
      write_csr(CSR_AXIS_TWO, a2);
      write_csr(CSR_AXIS_THREE, a3);
   endtask

   // all-zero registers: every determinant is zero, so everything is inside
   task automatic test_reset_config();
      send_point(0, 0, 0);
      send_point(MAXC, MAXC, MAXC);
      send_point(MINC, MINC, MINC);
      send_point(1, -1, 0);
   endtask

   task automatic test_axis_aligned();
      set_ellipsoid(pack_coords(10, -20, 30), pack_coords(100, 0, 0),
                    pack_coords(0, 200, 0), pack_coords(0, 0, 300));
      send_point(10, -20, 30);
      send_point(110, -20, 30);
      send_point(111, -20, 30);
      send_point(-50, 140, 30);
      send_point(10, -20, -270);
      send_point(10, -20, -271);
      send_point(MAXC, 0, MINC);
   endtask

   // dependent axes: inside only where all cramer terms vanish
   task automatic test_degenerate_axes();
      set_ellipsoid(pack_coords(-5, 3, 8), pack_coords(5, 7, -3),
                    pack_coords(10, 14, -6), pack_coords(1, 2, 3));
      send_point(-5, 3, 8);
      send_point(1, 12, 8);
      send_point(-4, 3, 8);
   endtask

   task automatic test_extreme_config();
      set_ellipsoid(with_spare(pack_coords(MAXC, MAXC, MAXC)),
                    with_spare(pack_coords(MINC, MAXC, MINC)),
                    with_spare(pack_coords(MAXC, MAXC, MINC)),
                    with_spare(pack_coords(MINC, MINC, MAXC)));
      send_point(MAXC, MAXC, MAXC);
      send_point(MINC, MINC, MINC);
      send_point(0, 0, 0);
      send_point(MAXC, MINC, 0);
      set_ellipsoid(pack_coords(MINC, MINC, MINC), '0, '0, '0);
      send_point(MINC, MINC, MINC);
      send_point(MAXC, MAXC, MAXC);
   endtask

   task automatic test_random_ellipsoids();
      int ctr [3];
      int ax [3][3];
      int k [3];
      int p [3];
      int cbits, abits, off, pick;
      logic [CSR_DATA_W-1:0] regs [4];
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin cbits = 6;  abits = 6;  end
            1: begin cbits = 12; abits = 12; end
            4: begin cbits = 1;  abits = 19; end
            5: begin cbits = 16; abits = 10; end
            default: begin cbits = 18; abits = 15; end
         endcase
         for (int d = 0; d < 3; d++) begin
            ctr[d] = rand_coord(cbits);
            for (int j = 0; j < 3; j++) ax[j][d] = rand_coord(abits);
            if (phase == 2) ax[2][d] = ax[0][d] + ax[1][d];
            if (phase == 6) ax[1][d] = 0;
         end
         regs[0] = with_spare(pack_coords(ctr[0], ctr[1], ctr[2]));
         for (int j = 0; j < 3; j++)
            regs[j+1] = with_spare(pack_coords(ax[j][0], ax[j][1], ax[j][2]));
         if (phase == 3 || phase == 7) begin
            for (int r = 0; r < 4; r++) regs[r] = {$urandom, $urandom};
         end
         set_ellipsoid(regs[0], regs[1], regs[2], regs[3]);
         // geometry as the block sees it, after truncation to the fields
         for (int d = 0; d < 3; d++) begin
            ctr[d]   = coord_at(csr_shadow[CSR_CENTER], d);
            ax[0][d] = coord_at(csr_shadow[CSR_AXIS_ONE], d);
            ax[1][d] = coord_at(csr_shadow[CSR_AXIS_TWO], d);
            ax[2][d] = coord_at(csr_shadow[CSR_AXIS_THREE], d);
         end
         idle_pct = (phase == 5) ? 0 : 11;
         for (int i = 0; i < 178; i++) begin
            if (i == 89 && (phase == 2 || phase == 6)) wait_all_results();
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               // exactly on the surface: center plus or minus one axis
               k = '{0, 0, 0};
               k[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 64 : -64;
            end else begin
               for (int j = 0; j < 3; j++) k[j] = $urandom_range(0, 144) - 72;
            end
            for (int d = 0; d < 3; d++) begin
               off = (k[0] * ax[0][d] + k[1] * ax[1][d] + k[2] * ax[2][d]) / 64;
               p[d] = ctr[d] + off;
               if (pick >= 10 && pick < 20) p[d] = p[d] + $urandom_range(0, 2) - 1;
            end
            if (pick >= 75)
               send_point($urandom, $urandom, $urandom);
            else
               send_point(p[0], p[1], p[2]);
         end
      end
      idle_pct = 11;
   endtask

   always @(posedge clock) begin : check_result
      query_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_inside.size() == 0) begin
            error_count++;
            $display("%0t: result with no item pending, inside_res=%b",
                     $time, rsp_inside_res);
         end else begin
            want = pending_inside.pop_front();
            if (rsp_inside_res !== want.hit) begin
               error_count++;
               $display("%0t: inside_res for point (%0d,%0d,%0d): expected %b, actual %b",
                        $time, want.x, want.y, want.z, want.hit, rsp_inside_res);
            end
         end
      end
   end

   initial begin
      for (int r = 0; r < 4; r++) csr_shadow[r] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_config();
      test_axis_aligned();
      test_degenerate_axes();
      test_extreme_config();
      test_random_ellipsoids();
      @(negedge clock);
      start = 1'b0;
      for (int n = 0; n < PIPE_DEPTH * 20 && pending_inside.size() != 0; n++)
         @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (pending_inside.size() != 0) begin
         error_count++;
         $display("%0t: %0d items never produced a result", $time, pending_inside.size());
      end
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire

[point_in_ellipsoid_test_top.f]
+incdir+rtl
rtl/pie_pkg.sv
rtl/pie_core.sv
rtl/point_in_ellipsoid_test_top.sv
bench/point_in_ellipsoid_test_top_test.sv
